// ----- sv/gpio_controller_event_detect_macros.svh -----
// Assertion macros for the GPIO controller with event detection.
// Each macro expands to a labeled concurrent assertion in simulation
// and to nothing when the design is synthesized.
`ifndef GPIO_CONTROLLER_EVENT_DETECT_MACROS_SVH
`define GPIO_CONTROLLER_EVENT_DETECT_MACROS_SVH

`ifndef SYNTHESIS

// The property holds at every clock edge outside reset.
`define GCED_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("gpio controller assertion failed");

// When the condition holds, the consequence holds in the next cycle.
`define GCED_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("gpio controller assertion failed");

`else

`define GCED_ASSERT(lbl, clk, rstn, prop)
`define GCED_ASSERT_NEXT(lbl, clk, rstn, pre, post)

`endif

`endif

// ----- sv/gced_pkg.sv -----
`default_nettype none

package gced_pkg;

  localparam int PinCount    = 58;
  localparam int HighWidth   = 26;
  localparam int FselWords   = 6;
  localparam int FselPerWord = 10;
  localparam int FselPins    = FselWords * FselPerWord;
  localparam int PullWords   = 4;
  localparam int PullPerWord = 16;

  typedef logic [PinCount-1:0] pins_t;

  typedef enum logic [1:0] {
    KindRead  = 2'd0,
    KindWrite = 2'd1,
    KindTick  = 2'd2
  } kind_e;

  typedef enum logic [4:0] {
    RegFsel0 = 5'd0,
    RegFsel5 = 5'd5,
    RegSet0  = 5'd6,
    RegSet1  = 5'd7,
    RegClr0  = 5'd8,
    RegClr1  = 5'd9,
    RegLev0  = 5'd10,
    RegLev1  = 5'd11,
    RegSts0  = 5'd12,
    RegSts1  = 5'd13,
    RegRise0 = 5'd14,
    RegRise1 = 5'd15,
    RegFall0 = 5'd16,
    RegFall1 = 5'd17,
    RegHigh0 = 5'd18,
    RegHigh1 = 5'd19,
    RegLow0  = 5'd20,
    RegLow1  = 5'd21,
    RegPull0 = 5'd22,
    RegPull3 = 5'd25
  } reg_e;

  typedef struct packed {
    logic [1:0]           kind;
    logic [4:0]           reg_index;
    logic [31:0]          write_data;
    logic [31:0]          pins_in_low;
    logic [HighWidth-1:0] pins_in_high;
  } in_t;

  typedef struct packed {
    logic [31:0]          read_data;
    logic [31:0]          drive_level_low;
    logic [HighWidth-1:0] drive_level_high;
    logic [31:0]          drive_enable_low;
    logic [HighWidth-1:0] drive_enable_high;
    logic                 irq_bank0;
    logic                 irq_bank1;
  } out_t;

  typedef struct packed {
    logic [PinCount-1:0][2:0] fsel;
    logic [PinCount-1:0][1:0] pull;
    pins_t                    latch;
    pins_t                    rise;
    pins_t                    fall;
    pins_t                    high;
    pins_t                    low;
    pins_t                    status;
    pins_t                    sample;
  } state_t;

  // Word of a banked pin vector: bank 0 is pins 0-31, bank 1 the rest.
  function automatic logic [31:0] bank_word(input pins_t v, input logic bank);
    logic [63:0] t;
    t = 64'(v);
    return bank ? t[63:32] : t[31:0];
  endfunction

  // Replace one bank of a pin vector with a word; pins that do not exist drop out.
  function automatic pins_t bank_put(input pins_t v, input logic bank,
                                     input logic [31:0] w);
    logic [63:0] t;
    t = 64'(v);
    if (bank) begin
      t[63:32] = w;
    end else begin
      t[31:0] = w;
    end
    return t[PinCount-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/gced_state.sv -----
`default_nettype none

module gced_state (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            upd_i,
  input  wire gced_pkg::in_t   item_i,
  output gced_pkg::state_t     st_q_o,
  output gced_pkg::state_t     st_d_o
);
  import gced_pkg::*;

  state_t                   st_q;
  state_t                   st_d;
  logic [PinCount-1:0][2:0] fsel_d;
  logic [PinCount-1:0][1:0] pull_d;
  pins_t                    latch_d;
  pins_t                    rise_d;
  pins_t                    fall_d;
  pins_t                    high_d;
  pins_t                    low_d;
  pins_t                    status_d;
  pins_t                    sample_d;
  pins_t                    smp;
  pins_t                    hit;
  logic                     wr;
  logic                     tick;
  logic                     bank;

  assign wr   = upd_i && (item_i.kind == KindWrite);
  assign tick = upd_i && (item_i.kind == KindTick);
  assign bank = item_i.reg_index[0];
  assign smp  = PinCount'(64'({item_i.pins_in_high, item_i.pins_in_low}));

  for (genvar p = 0; p < PinCount; p++) begin : g_pin
    localparam int PullWord = p / PullPerWord;
    localparam int PullSlot = p % PullPerWord;

    if (p < FselPins) begin : g_fsel
      localparam int FselWord = p / FselPerWord;
      localparam int FselSlot = p % FselPerWord;
      assign fsel_d[p] = (wr && item_i.reg_index == 5'(RegFsel0 + FselWord))
                         ? item_i.write_data[3*FselSlot +: 3] : st_q.fsel[p];
    end else begin : g_nofsel
      assign fsel_d[p] = st_q.fsel[p];
    end

    assign pull_d[p] = (wr && item_i.reg_index == 5'(RegPull0 + PullWord))
                       ? item_i.write_data[2*PullSlot +: 2] : st_q.pull[p];
  end

  always_comb begin
    latch_d  = st_q.latch;
    rise_d   = st_q.rise;
    fall_d   = st_q.fall;
    high_d   = st_q.high;
    low_d    = st_q.low;
    status_d = st_q.status;
    sample_d = st_q.sample;
    hit      = (st_q.rise & smp & ~st_q.sample)
             | (st_q.fall & ~smp & st_q.sample)
             | (st_q.high & smp)
             | (st_q.low & ~smp);
    if (wr) begin
      if (item_i.reg_index inside {RegSet0, RegSet1}) begin
        latch_d = st_q.latch | bank_put('0, bank, item_i.write_data);
      end
      if (item_i.reg_index inside {RegClr0, RegClr1}) begin
        latch_d = st_q.latch & ~bank_put('0, bank, item_i.write_data);
      end
      if (item_i.reg_index inside {RegSts0, RegSts1}) begin
        status_d = st_q.status & ~bank_put('0, bank, item_i.write_data);
      end
      if (item_i.reg_index inside {RegRise0, RegRise1}) begin
        rise_d = bank_put(st_q.rise, bank, item_i.write_data);
      end
      if (item_i.reg_index inside {RegFall0, RegFall1}) begin
        fall_d = bank_put(st_q.fall, bank, item_i.write_data);
      end
      if (item_i.reg_index inside {RegHigh0, RegHigh1}) begin
        high_d = bank_put(st_q.high, bank, item_i.write_data);
      end
      if (item_i.reg_index inside {RegLow0, RegLow1}) begin
        low_d = bank_put(st_q.low, bank, item_i.write_data);
      end
    end else if (tick) begin
      status_d = st_q.status | hit;
      sample_d = smp;
    end
  end

  assign st_d = '{fsel: fsel_d, pull: pull_d, latch: latch_d, rise: rise_d,
                  fall: fall_d, high: high_d, low: low_d, status: status_d,
                  sample: sample_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign st_q_o = st_q;
  assign st_d_o = st_d;

endmodule

`default_nettype wire

// ----- sv/gced_rdmux.sv -----
`default_nettype none

module gced_rdmux (
  input  wire gced_pkg::state_t st_i,
  input  wire logic [4:0]       reg_index_i,
  output logic [31:0]           rd_o
);
  import gced_pkg::*;

  wire logic [31:0] fsel_word [FselWords];
  wire logic [31:0] pull_word [PullWords];

  for (genvar r = 0; r < FselWords; r++) begin : g_fw
    for (genvar k = 0; k < FselPerWord; k++) begin : g_slot
      if (r * FselPerWord + k < PinCount) begin : g_pin
        assign fsel_word[r][3*k +: 3] = st_i.fsel[r * FselPerWord + k];
      end else begin : g_none
        assign fsel_word[r][3*k +: 3] = 3'b000;
      end
    end
    assign fsel_word[r][31:3*FselPerWord] = '0;
  end

  for (genvar q = 0; q < PullWords; q++) begin : g_pw
    for (genvar k = 0; k < PullPerWord; k++) begin : g_slot
      if (q * PullPerWord + k < PinCount) begin : g_pin
        assign pull_word[q][2*k +: 2] = st_i.pull[q * PullPerWord + k];
      end else begin : g_none
        assign pull_word[q][2*k +: 2] = 2'b00;
      end
    end
  end

  always_comb begin
    rd_o = '0;
    if (reg_index_i inside {[RegFsel0:RegFsel5]}) begin
      rd_o = fsel_word[3'(reg_index_i)];
    end else if (reg_index_i inside {[RegPull0:RegPull3]}) begin
      rd_o = pull_word[2'(reg_index_i - RegPull0)];
    end else begin
      case (reg_index_i)
        RegLev0, RegLev1:   rd_o = bank_word(st_i.sample, reg_index_i[0]);
        RegSts0, RegSts1:   rd_o = bank_word(st_i.status, reg_index_i[0]);
        RegRise0, RegRise1: rd_o = bank_word(st_i.rise, reg_index_i[0]);
        RegFall0, RegFall1: rd_o = bank_word(st_i.fall, reg_index_i[0]);
        RegHigh0, RegHigh1: rd_o = bank_word(st_i.high, reg_index_i[0]);
        RegLow0, RegLow1:   rd_o = bank_word(st_i.low, reg_index_i[0]);
        default:            rd_o = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/gpio_controller_event_detect.sv -----
// An accepted transaction waits in the input register until the result register can take it.
// Throughput: one transaction per cycle while the result register is not full and stalled.
// Reset: rst_ni is asynchronous and active low; it clears all pin state and both valid flags.
// After reset all pins are inputs with no pull, latches, enables, status and samples are zero.
`default_nettype none

`include "gpio_controller_event_detect_macros.svh"

module gpio_controller_event_detect (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire gced_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output gced_pkg::out_t     out_data_o
);
  import gced_pkg::*;

  // Input register. A transaction sits here, and stays while the result
  // register is full and stalled, as the state module applies it and the
  // read mux picks its read word.
  logic   in_vld_q;
  logic   in_vld_d;
  in_t    in_q;

  // Result register. It parts the two sides, so a new transaction enters
  // while the previous result still waits to be taken.
  logic   out_vld_q;
  logic   out_vld_d;
  out_t   out_q;
  out_t   res_d;

  logic   out_ready;
  logic   adv;
  logic   in_acc;
  logic [31:0] rd;
  pins_t  drv;
  state_t st_q;
  state_t st_d;

  // The result register can take a new value when it is empty or its
  // value is leaving in this cycle.
  assign out_ready  = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_ready;
  assign in_stall_o = in_vld_q && !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Pin state only changes when the held transaction moves on to the
  // result register, so every read sees all earlier writes and ticks.
  gced_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (adv),
    .item_i (in_q),
    .st_q_o (st_q),
    .st_d_o (st_d)
  );

  // Reads return the register word as it stands before the transaction.
  gced_rdmux u_rdmux (
    .st_i        (st_q),
    .reg_index_i (in_q.reg_index),
    .rd_o        (rd)
  );

  // The outputs other than read data show the state after the transaction.
  for (genvar p = 0; p < PinCount; p++) begin : g_drv
    assign drv[p] = (st_d.fsel[p] == 3'd1);
  end

  always_comb begin
    res_d.read_data         = (in_q.kind == KindRead) ? rd : '0;
    res_d.drive_level_low   = bank_word(st_d.latch, 1'b0);
    res_d.drive_level_high  = HighWidth'(bank_word(st_d.latch, 1'b1));
    res_d.drive_enable_low  = bank_word(drv, 1'b0);
    res_d.drive_enable_high = HighWidth'(bank_word(drv, 1'b1));
    res_d.irq_bank0         = |bank_word(st_d.status, 1'b0);
    res_d.irq_bank1         = |bank_word(st_d.status, 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A transaction that moves on always shows up as a result.
  `GCED_ASSERT_NEXT(a_adv_gives_result, clk_i, rst_ni, adv, out_vld_q)

  // The input side is held back only by a full, stalled result register.
  `GCED_ASSERT(a_stall_cause, clk_i, rst_ni, !in_stall_o || (out_vld_q && out_stall_i))

  // Pin state is untouched while no transaction moves on.
  `GCED_ASSERT_NEXT(a_state_hold, clk_i, rst_ni, !adv, $stable(st_q))

  // A waiting result agrees with the state it was taken from.
  `GCED_ASSERT(a_irq0_match, clk_i, rst_ni,
               !out_vld_q || (out_q.irq_bank0 == (|bank_word(st_q.status, 1'b0))))
  `GCED_ASSERT(a_irq1_match, clk_i, rst_ni,
               !out_vld_q || (out_q.irq_bank1 == (|bank_word(st_q.status, 1'b1))))

endmodule

`default_nettype wire
